[hw/rtl/ppd_pkg.sv]
// shared types and constants for the preamble packet deframer
package ppd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [BYTE_W-1:0] LEN_OFFSET = 8'd6;

  typedef enum logic [2:0] {
    ST_PRE1 = 3'd0,
    ST_PRE2 = 3'd1,
    ST_PRE3 = 3'd2,
    ST_CSUM = 3'd3,
    ST_LEN  = 3'd4,
    ST_TYPE = 3'd5,
    ST_DATA = 3'd6,
    ST_HUNT = 3'd7
  } parse_state_t;

  typedef enum logic [CODE_W-1:0] {
    ERR_PRE1   = 3'd0,
    ERR_PRE2   = 3'd1,
    ERR_PRE3   = 3'd2,
    ERR_CSUM   = 3'd3,
    ERR_LENGTH = 3'd4
  } err_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PREAMBLE_FIRST  = 2'd0,
    REG_PREAMBLE_SECOND = 2'd1,
    REG_PREAMBLE_THIRD  = 2'd2
  } cfg_reg_t;

  // one result item, tdata fields plus packet_end
  typedef struct packed {
    logic              packet_end;
    logic [CODE_W-1:0] error_code;
    logic              error_flag;
    logic [BYTE_W-1:0] payload_length;
    logic [BYTE_W-1:0] packet_type;
    logic              packet_ok;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
  } result_t;

  localparam int unsigned OUT_FIELDS_W = $bits(result_t) - 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

[hw/rtl/preamble_packet_deframer.sv]
// preamble packet deframer top level: parser state machine and output skid stage
//
// channel   dir  handshake                    content
// s_axis    in   s_axis_tvalid/tready         tdata = rx_byte
// m_axis    out  m_axis_tvalid/tready         tdata = result fields, tlast = packet_end
// cfg       in   cfg_we                       cfg_index selects preamble register
//
// a byte is taken each cycle while s_axis_tready is high; results are registered
// the parser state updates at the same edge that takes the byte
// rst resets the parser and the preamble registers and empties both output stages
// a stalled result sits in the output register; one more goes to the skid
// stage, and s_axis_tready falls only while the skid stage is full
module preamble_packet_deframer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ppd_pkg::BYTE_W-1:0]           s_axis_tdata,  // [7:0] rx_byte
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] has_data, [8:1] data_byte, [16:9] byte_index, [17] packet_ok,
  // [25:18] packet_type, [33:26] payload_length, [34] error_flag,
  // [37:35] error_code, [39:38] zero
  output logic [ppd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast,  // packet_end
  input  logic                                 cfg_we,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppd_pkg::BYTE_W-1:0]           cfg_data
);

  logic [ppd_pkg::BYTE_W-1:0] preamble_first;
  logic [ppd_pkg::BYTE_W-1:0] preamble_second;
  logic [ppd_pkg::BYTE_W-1:0] preamble_third;

  ppd_pkg::parse_state_t      state, state_next;
  logic [ppd_pkg::BYTE_W-1:0] expected_checksum, expected_checksum_next;
  logic [ppd_pkg::BYTE_W-1:0] running_xor, running_xor_next;
  logic [ppd_pkg::BYTE_W-1:0] payload_count, payload_count_next;
  logic [ppd_pkg::BYTE_W-1:0] payload_total, payload_total_next;
  logic [ppd_pkg::BYTE_W-1:0] current_type, current_type_next;

  ppd_pkg::result_t res;
  logic             res_valid;
  logic             accept;
  logic [ppd_pkg::BYTE_W-1:0] rx_byte;
  logic [ppd_pkg::BYTE_W-1:0] xor_folded;
  logic [ppd_pkg::BYTE_W-1:0] count_inc;

  ppd_pkg::result_t out_res;
  logic             out_valid;
  ppd_pkg::result_t skid_res;
  logic             skid_valid;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign xor_folded    = running_xor ^ rx_byte;
  assign count_inc     = payload_count + 8'd1;

  // preamble registers
  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_first  <= 8'd3;
      preamble_second <= 8'd239;
      preamble_third  <= 8'd175;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppd_pkg::REG_PREAMBLE_FIRST:  preamble_first  <= cfg_data;
        ppd_pkg::REG_PREAMBLE_SECOND: preamble_second <= cfg_data;
        ppd_pkg::REG_PREAMBLE_THIRD:  preamble_third  <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ppd_pkg::ST_PRE1;
      expected_checksum <= '0;
      running_xor       <= '0;
      payload_count     <= '0;
      payload_total     <= '0;
      current_type      <= '0;
    end else if (accept) begin
      state             <= state_next;
      expected_checksum <= expected_checksum_next;
      running_xor       <= running_xor_next;
      payload_count     <= payload_count_next;
      payload_total     <= payload_total_next;
      current_type      <= current_type_next;
    end
  end

  always_comb begin
    state_next             = state;
    expected_checksum_next = expected_checksum;
    running_xor_next       = running_xor;
    payload_count_next     = payload_count;
    payload_total_next     = payload_total;
    current_type_next      = current_type;
    res                    = '0;
    res_valid              = 1'b0;
    unique case (state)
      ppd_pkg::ST_PRE1: begin
        if (rx_byte == preamble_first) begin
          state_next = ppd_pkg::ST_PRE2;
        end else begin
          res_valid      = 1'b1;
          res.error_flag = 1'b1;
          res.error_code = ppd_pkg::ERR_PRE1;
          state_next     = ppd_pkg::ST_HUNT;
        end
      end
      ppd_pkg::ST_PRE2: begin
        if (rx_byte == preamble_second) begin
          state_next = ppd_pkg::ST_PRE3;
        end else begin
          res_valid      = 1'b1;
          res.error_flag = 1'b1;
          res.error_code = ppd_pkg::ERR_PRE2;
          state_next     = ppd_pkg::ST_HUNT;
        end
      end
      ppd_pkg::ST_PRE3: begin
        if (rx_byte == preamble_third) begin
          state_next = ppd_pkg::ST_CSUM;
        end else begin
          res_valid      = 1'b1;
          res.error_flag = 1'b1;
          res.error_code = ppd_pkg::ERR_PRE3;
          state_next     = ppd_pkg::ST_HUNT;
        end
      end
      ppd_pkg::ST_CSUM: begin
        expected_checksum_next = rx_byte;
        state_next             = ppd_pkg::ST_LEN;
      end
      ppd_pkg::ST_LEN: begin
        if (rx_byte >= ppd_pkg::LEN_OFFSET) begin
          payload_total_next = rx_byte - ppd_pkg::LEN_OFFSET;
          running_xor_next   = preamble_first ^ preamble_second ^ preamble_third ^ rx_byte;
          state_next         = ppd_pkg::ST_TYPE;
        end else begin
          res_valid      = 1'b1;
          res.error_flag = 1'b1;
          res.error_code = ppd_pkg::ERR_LENGTH;
          state_next     = ppd_pkg::ST_HUNT;
        end
      end
      ppd_pkg::ST_TYPE: begin
        current_type_next  = rx_byte;
        running_xor_next   = xor_folded;
        payload_count_next = '0;
        if (payload_total != '0) begin
          state_next = ppd_pkg::ST_DATA;
        end else begin
          res_valid          = 1'b1;
          res.packet_end     = 1'b1;
          res.packet_type    = rx_byte;
          res.payload_length = payload_total;
          if (xor_folded == expected_checksum) begin
            res.packet_ok = 1'b1;
            state_next    = ppd_pkg::ST_PRE1;
          end else begin
            res.error_flag = 1'b1;
            res.error_code = ppd_pkg::ERR_CSUM;
            state_next     = ppd_pkg::ST_HUNT;
          end
        end
      end
      ppd_pkg::ST_DATA: begin
        res_valid          = 1'b1;
        res.has_data       = 1'b1;
        res.data_byte      = rx_byte;
        res.byte_index     = payload_count;
        res.packet_type    = current_type;
        res.payload_length = payload_total;
        running_xor_next   = xor_folded;
        payload_count_next = count_inc;
        if (count_inc >= payload_total) begin
          res.packet_end = 1'b1;
          if (xor_folded == expected_checksum) begin
            res.packet_ok = 1'b1;
            state_next    = ppd_pkg::ST_PRE1;
          end else begin
            res.error_flag = 1'b1;
            res.error_code = ppd_pkg::ERR_CSUM;
            state_next     = ppd_pkg::ST_HUNT;
          end
        end
      end
      ppd_pkg::ST_HUNT: begin
        if (rx_byte == preamble_first) begin
          state_next = ppd_pkg::ST_PRE2;
        end
      end
      default: state_next = ppd_pkg::ST_HUNT;
    endcase
  end

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!(m_axis_tready || !out_valid) && !skid_valid) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.packet_end;
  assign m_axis_tdata  = {{(ppd_pkg::OUT_TDATA_W - ppd_pkg::OUT_FIELDS_W){1'b0}},
                          out_res[ppd_pkg::OUT_FIELDS_W-1:0]};

  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with output register empty");

  // framing errors leave the parser hunting
  a_error_hunts: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res.error_flag |=> state == ppd_pkg::ST_HUNT)
    else $error("error result without hunt state");

  // checksum failure always closes a packet and is never accepted
  a_csum_closes: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.error_flag && res.error_code == ppd_pkg::ERR_CSUM
    |-> res.packet_end && !res.packet_ok)
    else $error("checksum error outside packet end");

  // payload index stays inside the packet
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.has_data |-> res.byte_index < res.payload_length)
    else $error("payload index beyond packet length");

  // a good packet returns the parser to the first preamble
  a_ok_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && res_valid && res.packet_ok |=> state == ppd_pkg::ST_PRE1)
    else $error("accepted packet did not restart parser");

endmodule
